FILE: hdl/bmon_pkg.sv
// battery level monitor: shared constants, codes and beat structs
// no dependencies; imported by every module of the block

package bmon_pkg;

   localparam int unsigned CHECK_PERIOD = 360;
   localparam int unsigned DAY_TICKS = 8640;

   localparam int unsigned MV_W = 13;
   localparam int unsigned TICK_W = 32;
   localparam int unsigned AGE_W = 16;
   localparam int unsigned CNT_W = 2;

   // floor(2^32 / n): quotient estimate is exact or one short
   localparam logic [TICK_W-1:0] CHK_RECIP =
      TICK_W'((64'd1 << TICK_W) / 64'(CHECK_PERIOD));
   localparam logic [TICK_W-1:0] DAY_RECIP =
      TICK_W'((64'd1 << TICK_W) / 64'(DAY_TICKS));

   // remainder before correction stays below twice the divisor
   localparam int unsigned CHK_REM_W = $clog2(2 * CHECK_PERIOD);
   localparam int unsigned DAY_REM_W = $clog2(2 * DAY_TICKS);

   localparam logic [CHK_REM_W-1:0] CHK_DIV = CHK_REM_W'(CHECK_PERIOD);
   localparam logic [CHK_REM_W-1:0] CHK_SLOT = CHK_REM_W'(CHECK_PERIOD - 4);
   localparam logic [DAY_REM_W-1:0] DAY_DIV = DAY_REM_W'(DAY_TICKS);
   localparam logic [DAY_REM_W-1:0] DAY_LAST = DAY_REM_W'(DAY_TICKS - 1);

   localparam logic [AGE_W-1:0] DAY_MODE_MIN = AGE_W'(2);
   localparam logic [CNT_W-1:0] LOW_CONFIRM = CNT_W'(2);

   typedef enum logic [1:0] {
      CSR_FULL_THR       = 2'd0,
      CSR_TWO_THIRDS_THR = 2'd1,
      CSR_ONE_THIRD_THR  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      LEVEL_EMPTY = 2'd0,
      LEVEL_LOW   = 2'd1,
      LEVEL_MID   = 2'd2,
      LEVEL_FULL  = 2'd3
   } level_type;

   localparam logic [MV_W-1:0] FULL_THR_RESET = MV_W'(3000);
   localparam logic [MV_W-1:0] TWO_THIRDS_THR_RESET = MV_W'(2800);
   localparam logic [MV_W-1:0] ONE_THIRD_THR_RESET = MV_W'(2600);

   typedef struct packed {
      logic [MV_W-1:0]   battery_mv;
      logic [TICK_W-1:0] idle_ticks;
      logic [AGE_W-1:0]  age_days;
   } req_data_type;

   typedef struct packed {
      logic [1:0] battery_level;
      logic       checked;
      logic       low_power_error;
      logic       low_alarm_event;
   } rsp_data_type;

   typedef struct packed {
      logic [MV_W-1:0] full;
      logic [MV_W-1:0] two_thirds;
      logic [MV_W-1:0] one_third;
   } thr_type;

   typedef struct packed {
      logic [MV_W-1:0]  battery_mv;
      logic [AGE_W-1:0] age_days;
      logic             check_slot;
      logic             day_end;
   } sched_beat_type;

endpackage

FILE: hdl/bmon_tick_sched.sv
// battery level monitor: input register and tick schedule pipeline
// finds the check slot and day end from the tick count by reciprocal multiply
// depends on bmon_pkg

module bmon_tick_sched (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  bmon_pkg::req_data_type   req_data,
   output logic                     beat_valid,
   input  logic                     beat_ready,
   output bmon_pkg::sched_beat_type beat
);
   import bmon_pkg::*;

   logic                 s0_valid_ff, s0_valid_in;
   req_data_type         s0_ff;
   logic                 s1_valid_ff, s1_valid_in;
   logic [TICK_W-1:0]    s1_chk_q_ff, s1_day_q_ff;
   logic [CHK_REM_W-1:0] s1_chk_ticks_ff;
   logic [DAY_REM_W-1:0] s1_day_ticks_ff;
   logic [MV_W-1:0]      s1_mv_ff;
   logic [AGE_W-1:0]     s1_age_ff;
   logic                 s2_valid_ff, s2_valid_in;
   sched_beat_type       s2_ff, s2_in;

   logic                 ready0, ready1, ready2;
   logic [2*TICK_W-1:0]  chk_prod, day_prod;
   logic [CHK_REM_W-1:0] chk_raw, chk_rem;
   logic [DAY_REM_W-1:0] day_raw, day_rem;

   assign ready2 = !s2_valid_ff || beat_ready;
   assign ready1 = !s1_valid_ff || ready2;
   assign ready0 = !s0_valid_ff || ready1;
   assign req_ready = ready0;

   assign s0_valid_in = ready0 ? req_valid : s0_valid_ff;
   assign s1_valid_in = ready1 ? s0_valid_ff : s1_valid_ff;
   assign s2_valid_in = ready2 ? s1_valid_ff : s2_valid_ff;

   // quotient estimates
   assign chk_prod = (2*TICK_W)'(s0_ff.idle_ticks) * (2*TICK_W)'(CHK_RECIP);
   assign day_prod = (2*TICK_W)'(s0_ff.idle_ticks) * (2*TICK_W)'(DAY_RECIP);

   // remainders with one correction step
   always_comb begin
      chk_raw = s1_chk_ticks_ff - s1_chk_q_ff[CHK_REM_W-1:0] * CHK_DIV;
      chk_rem = (chk_raw >= CHK_DIV) ? chk_raw - CHK_DIV : chk_raw;
      day_raw = s1_day_ticks_ff - s1_day_q_ff[DAY_REM_W-1:0] * DAY_DIV;
      day_rem = (day_raw >= DAY_DIV) ? day_raw - DAY_DIV : day_raw;
      s2_in.battery_mv = s1_mv_ff;
      s2_in.age_days = s1_age_ff;
      s2_in.check_slot = (chk_rem == CHK_SLOT);
      s2_in.day_end = (day_rem == DAY_LAST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready0) begin
         s0_ff <= req_data;
      end
      if (ready1) begin
         s1_chk_q_ff <= chk_prod[2*TICK_W-1:TICK_W];
         s1_day_q_ff <= day_prod[2*TICK_W-1:TICK_W];
         s1_chk_ticks_ff <= s0_ff.idle_ticks[CHK_REM_W-1:0];
         s1_day_ticks_ff <= s0_ff.idle_ticks[DAY_REM_W-1:0];
         s1_mv_ff <= s0_ff.battery_mv;
         s1_age_ff <= s0_ff.age_days;
      end
      if (ready2) begin
         s2_ff <= s2_in;
      end
   end

   assign beat_valid = s2_valid_ff;
   assign beat = s2_ff;

endmodule

FILE: hdl/bmon_level_core.sv
// battery level monitor: level, debounce and day tracker state, result register
// depends on bmon_pkg

module bmon_level_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     beat_valid,
   output logic                     beat_ready,
   input  bmon_pkg::sched_beat_type beat,
   input  bmon_pkg::thr_type        thr,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output bmon_pkg::rsp_data_type   rsp_data
);
   import bmon_pkg::*;

   level_type        level_ff, level_in;
   logic             armed_ff, armed_in;
   logic [CNT_W-1:0] low_count_ff, low_count_in;
   logic [AGE_W-1:0] days_seen_ff, days_seen_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_data_type     rsp_ff, rsp_in;

   logic      fire, pending, run, alarm;
   level_type quant;

   assign beat_ready = !rsp_valid_ff || rsp_ready;
   assign fire = beat_valid && beat_ready;

   always_comb begin
      if (beat.battery_mv >= thr.full) begin
         quant = LEVEL_FULL;
      end else if (beat.battery_mv >= thr.two_thirds) begin
         quant = LEVEL_MID;
      end else if (beat.battery_mv >= thr.one_third) begin
         quant = LEVEL_LOW;
      end else begin
         quant = LEVEL_EMPTY;
      end
   end

   always_comb begin
      pending = (low_count_ff != '0) || (level_ff == LEVEL_EMPTY);
      days_seen_in = days_seen_ff;
      level_in = level_ff;
      armed_in = armed_ff;
      low_count_in = low_count_ff;
      alarm = 1'b0;
      if (days_seen_ff >= DAY_MODE_MIN) begin
         run = (days_seen_ff != beat.age_days) || pending;
         if (run) begin
            days_seen_in = beat.age_days;
         end
      end else begin
         run = beat.check_slot || pending;
         if (beat.day_end) begin
            days_seen_in = days_seen_ff + AGE_W'(1);
         end
      end
      if (run) begin
         level_in = quant;
         if (quant == LEVEL_EMPTY && armed_ff) begin
            if (low_count_ff >= LOW_CONFIRM) begin
               low_count_in = '0;
               armed_in = 1'b0;
               alarm = 1'b1;
            end else begin
               low_count_in = low_count_ff + CNT_W'(1);
            end
         end else begin
            low_count_in = '0;
         end
      end
      rsp_in.battery_level = level_in;
      rsp_in.checked = run;
      rsp_in.low_power_error = !armed_in && (level_in == LEVEL_EMPTY);
      rsp_in.low_alarm_event = alarm;
      rsp_valid_in = fire ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= LEVEL_FULL;
         armed_ff <= 1'b1;
         low_count_ff <= '0;
         days_seen_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            level_ff <= level_in;
            armed_ff <= armed_in;
            low_count_ff <= low_count_in;
            days_seen_ff <= days_seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

FILE: hdl/battery_level_monitor_top.sv
// battery level monitor top level: threshold registers, schedule pipeline, level core
// depends on bmon_pkg, bmon_tick_sched, bmon_level_core
//
// usage
//   req channel: one beat per wake tick carrying battery_mv, idle_ticks and
//   age_days; rsp channel: one beat back per request beat, in order, with the
//   level, the checked flag, the low-power error and the alarm pulse
//   csr port: csr_we writes csr_wdata into the threshold chosen by csr_index
//   (0 full, 1 two thirds, 2 one third); other indexes are ignored
//   path to rsp: input register, quotient multiply, remainder compare, result
//   register; throughput: one beat per cycle while rsp_ready is high; the two
//   32x32 reciprocal multiplies sit in their own stage, the state update and
//   result register in the last one
//   reset: thresholds go to 3000/2800/2600 mV, level full, armed, day tracker 0;
//   the pipeline empties
//   stall: while rsp_ready is low the result holds and each stage still takes
//   a beat if it is empty, so up to four beats are held before req_ready drops

module battery_level_monitor_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bmon_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bmon_pkg::rsp_data_type rsp_data,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [bmon_pkg::MV_W-1:0] csr_wdata
);
   import bmon_pkg::*;

   thr_type        thr_ff;
   logic           beat_valid, beat_ready;
   sched_beat_type beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.full <= FULL_THR_RESET;
         thr_ff.two_thirds <= TWO_THIRDS_THR_RESET;
         thr_ff.one_third <= ONE_THIRD_THR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FULL_THR:       thr_ff.full <= csr_wdata;
            CSR_TWO_THIRDS_THR: thr_ff.two_thirds <= csr_wdata;
            CSR_ONE_THIRD_THR:  thr_ff.one_third <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   bmon_tick_sched u_sched (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .beat_valid (beat_valid),
      .beat_ready (beat_ready),
      .beat       (beat)
   );

   bmon_level_core u_core (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (beat_valid),
      .beat_ready (beat_ready),
      .beat       (beat),
      .thr        (thr_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: tb/tb_top.sv
// battery level monitor testbench: directed and random wake ticks, threshold register phases
// depends on bmon_pkg and battery_level_monitor_top; in-order scoreboard fed by a
// cycle-free predictor of the level, debounce and day tracking

module tb_top;
   import bmon_pkg::*;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam logic [MV_W-1:0] MV_MAX = '1;
   localparam int unsigned MV_TOP = (1 << MV_W) - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_data_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_data_type rsp_data;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [MV_W-1:0] csr_wdata = '0;

   // predicted monitor state
   logic [MV_W-1:0] thr_full;
   logic [MV_W-1:0] thr_two_thirds;
   logic [MV_W-1:0] thr_one_third;
   level_type cur_level;
   logic armed_now;
   logic [CNT_W-1:0] empty_run;
   logic [AGE_W-1:0] day_tracker;

   rsp_data_type level_reports_q[$];
   rsp_data_type want_rsp;
   int mismatch_cnt = 0;
   int burst_left = 0;
   int stall_left = 0;

   battery_level_monitor_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("tb_top NOT OK");
      $finish;
   end

   function automatic level_type quantize_mv(input logic [MV_W-1:0] mv);
      if (mv >= thr_full) return LEVEL_FULL;
      if (mv >= thr_two_thirds) return LEVEL_MID;
      if (mv >= thr_one_third) return LEVEL_LOW;
      return LEVEL_EMPTY;
   endfunction

   task automatic init_monitor_state();
      thr_full = FULL_THR_RESET;
      thr_two_thirds = TWO_THIRDS_THR_RESET;
      thr_one_third = ONE_THIRD_THR_RESET;
      cur_level = LEVEL_FULL;
      armed_now = 1'b1;
      empty_run = '0;
      day_tracker = '0;
   endtask

   task automatic evaluate_level(input logic [MV_W-1:0] mv, output logic alarm);
      alarm = 1'b0;
      cur_level = quantize_mv(mv);
      if (cur_level == LEVEL_EMPTY && armed_now) begin
         if (empty_run >= LOW_CONFIRM) begin
            empty_run = '0;
            armed_now = 1'b0;
            alarm = 1'b1;
         end else begin
            empty_run = empty_run + 1'b1;
         end
      end else begin
         empty_run = '0;
      end
   endtask

   task automatic predict_tick(input req_data_type d);
      rsp_data_type r;
      logic pending;
      logic alarm;
      r = '0;
      alarm = 1'b0;
      pending = (empty_run != 0) || (cur_level == LEVEL_EMPTY);
      if (day_tracker >= DAY_MODE_MIN) begin
         if (day_tracker != d.age_days || pending) begin
            day_tracker = d.age_days;
            r.checked = 1'b1;
            evaluate_level(d.battery_mv, alarm);
         end
      end else begin
         if (d.idle_ticks % CHECK_PERIOD == CHECK_PERIOD - 4 || pending) begin
            r.checked = 1'b1;
            evaluate_level(d.battery_mv, alarm);
         end
         if (d.idle_ticks % DAY_TICKS == DAY_TICKS - 1) day_tracker = day_tracker + 1'b1;
      end
      r.battery_level = cur_level;
      r.low_power_error = !armed_now && cur_level == LEVEL_EMPTY;
      r.low_alarm_event = alarm;
      level_reports_q.push_back(r);
   endtask

   task automatic flag_error(input string what);
      mismatch_cnt++;
      if (mismatch_cnt <= 10) $display("mismatch: %s", what);
   endtask

   // receiver: free-flowing stretches, hard stalls and random ready
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         case ($urandom_range(0, 7))
            0, 1: begin
               rsp_ready <= 1'b1;
               stall_left <= $urandom_range(10, 60);
            end
            2: begin
               rsp_ready <= 1'b0;
               stall_left <= $urandom_range(1, 20);
            end
            default: rsp_ready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (level_reports_q.size() == 0) begin
            flag_error($sformatf("unexpected beat level %0d chk %b err %b alarm %b",
                       rsp_data.battery_level, rsp_data.checked,
                       rsp_data.low_power_error, rsp_data.low_alarm_event));
         end else begin
            want_rsp = level_reports_q.pop_front();
            if (rsp_data.battery_level !== want_rsp.battery_level ||
                rsp_data.checked !== want_rsp.checked ||
                rsp_data.low_power_error !== want_rsp.low_power_error ||
                rsp_data.low_alarm_event !== want_rsp.low_alarm_event)
               flag_error($sformatf(
                  "want level %0d chk %b err %b alarm %b, got level %0d chk %b err %b alarm %b",
                  want_rsp.battery_level, want_rsp.checked, want_rsp.low_power_error,
                  want_rsp.low_alarm_event, rsp_data.battery_level, rsp_data.checked,
                  rsp_data.low_power_error, rsp_data.low_alarm_event));
         end
      end
   end

   task automatic send_tick(input req_data_type d);
      req_valid <= 1'b1;
      req_data <= d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_tick(d);
   endtask

   task automatic send_fields(input logic [MV_W-1:0] mv, input logic [TICK_W-1:0] ticks,
                              input logic [AGE_W-1:0] age);
      req_data_type d;
      d.battery_mv = mv;
      d.idle_ticks = ticks;
      d.age_days = age;
      send_tick(d);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (level_reports_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [MV_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_FULL_THR:       thr_full = val;
         CSR_TWO_THIRDS_THR: thr_two_thirds = val;
         CSR_ONE_THIRD_THR:  thr_one_third = val;
         default: ;
      endcase
   endtask

   task automatic set_thresholds(input logic [MV_W-1:0] full, input logic [MV_W-1:0] two,
                                 input logic [MV_W-1:0] one);
      settle();
      write_csr(CSR_FULL_THR, full);
      write_csr(CSR_TWO_THIRDS_THR, two);
      write_csr(CSR_ONE_THIRD_THR, one);
      csr_we <= 1'b0;
   endtask

   task automatic set_sorted_thresholds();
      int unsigned one;
      int unsigned two;
      one = $urandom_range(0, MV_TOP);
      two = $urandom_range(one, MV_TOP);
      set_thresholds(MV_W'($urandom_range(two, MV_TOP)), MV_W'(two), MV_W'(one));
   endtask

   function automatic logic [TICK_W-1:0] tick_with_residue(input int unsigned period,
                                                           input int unsigned residue);
      longint unsigned v;
      v = $urandom;
      v = v - (v % period) + residue;
      if (v > 64'hFFFF_FFFF) v = v - period;
      return TICK_W'(v);
   endfunction

   function automatic logic [MV_W-1:0] pick_mv();
      int v;
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return MV_W'($urandom_range(0, MV_TOP));
      if (r == 1) return '0;
      if (r == 2) return MV_MAX;
      case ($urandom_range(0, 2))
         0: v = int'(thr_full);
         1: v = int'(thr_two_thirds);
         default: v = int'(thr_one_third);
      endcase
      v = v + int'($urandom_range(0, 4)) - 2;
      if (v < 0) v = 0;
      if (v > int'(MV_TOP)) v = MV_TOP;
      return MV_W'(v);
   endfunction

   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send_random_tick(input bit keep_armed);
      req_data_type d;
      int r;
      d.battery_mv = pick_mv();
      if (keep_armed && armed_now && empty_run >= LOW_CONFIRM &&
          quantize_mv(d.battery_mv) == LEVEL_EMPTY)
         d.battery_mv = MV_MAX;
      d.idle_ticks = $urandom;
      d.age_days = AGE_W'($urandom);
      r = $urandom_range(0, 19);
      if (day_tracker >= DAY_MODE_MIN) begin
         if (r < 8) d.age_days = day_tracker;
         else if (r < 14) d.age_days = day_tracker + 1'b1;
         else if (r < 16) d.age_days = AGE_W'($urandom_range(0, 1));
         else if (r < 18) d.age_days = AGE_W'($urandom_range(2, 5));
      end else begin
         if (r < 8) d.idle_ticks = tick_with_residue(CHECK_PERIOD, CHECK_PERIOD - 4);
         else if (r < 11) d.idle_ticks = tick_with_residue(DAY_TICKS, DAY_TICKS - 1);
         else if (r == 11) d.idle_ticks = tick_with_residue(CHECK_PERIOD, CHECK_PERIOD - 5);
         else if (r == 12) d.idle_ticks = tick_with_residue(CHECK_PERIOD, CHECK_PERIOD - 3);
      end
      send_tick(d);
   endtask

   task automatic run_random_ticks(input int n, input bit keep_armed);
      for (int i = 0; i < n; i++) begin
         pace_sender();
         if ($urandom_range(0, 149) == 0) settle();
         send_random_tick(keep_armed);
      end
   endtask

   task automatic test_level_bands();
      send_fields(13'd3000, 32'd356, 16'd0);
      send_fields(13'd2999, 32'd716, 16'd0);
      send_fields(13'd2800, 32'd100, 16'd0);
      send_fields(13'd2799, 32'd1076, 16'd0);
      send_fields(13'd2600, 32'd356, 16'd0);
   endtask

   task automatic test_empty_debounce();
      send_fields(13'd2599, 32'd356, 16'd0);
      send_fields(13'd0, 32'd5, 16'd0);
      send_fields(MV_MAX, 32'd7, 16'd0);
      send_fields(13'd1000, 32'd356, 16'd0);
      send_fields(13'd2650, 32'd9, 16'd0);
   endtask

   task automatic test_field_extremes();
      send_fields(MV_MAX, 32'hFFFF_FFFF, 16'hFFFF);
      send_fields(13'd0, 32'd0, 16'd0);
   endtask

   task automatic test_day_tracking();
      send_fields(13'd3000, 32'd8639, 16'd0);
      send_fields(13'd2900, 32'd17279, 16'd0);
      send_fields(13'd2900, 32'd12345, 16'd2);
      send_fields(13'd2900, 32'd12346, 16'd3);
      send_fields(13'd3100, 32'd12347, 16'd3);
      send_fields(MV_MAX, 32'd12348, 16'hFFFF);
      send_fields(13'd2700, 32'd12349, 16'd1);
   endtask

   task automatic test_threshold_registers();
      set_thresholds('0, '0, '0);
      send_fields(13'd0, 32'd356, 16'd0);
      set_thresholds(MV_MAX, MV_MAX, MV_MAX);
      send_fields(13'd8190, 32'd356, 16'd0);
      send_fields(MV_MAX, 32'd11, 16'd0);
      set_thresholds(13'd1000, 13'd5000, 13'd3000);
      send_fields(13'd4000, 32'd356, 16'd0);
      send_fields(13'd999, 32'd356, 16'd0);
      send_fields(13'd3500, 32'd13, 16'd0);
      settle();
      write_csr(CSR_UNUSED, '0);
      csr_we <= 1'b0;
      send_fields(13'd2000, 32'd356, 16'd0);
   endtask

   task automatic test_random_armed();
      set_thresholds(FULL_THR_RESET, TWO_THIRDS_THR_RESET, ONE_THIRD_THR_RESET);
      run_random_ticks(90, 1'b1);
      set_sorted_thresholds();
      run_random_ticks(90, 1'b1);
      set_thresholds('0, '0, '0);
      run_random_ticks(90, 1'b1);
      set_thresholds(MV_W'($urandom), MV_W'($urandom), MV_W'($urandom));
      run_random_ticks(90, 1'b1);
      set_sorted_thresholds();
      run_random_ticks(90, 1'b1);
   endtask

   task automatic test_random_unrestricted();
      set_thresholds(FULL_THR_RESET, TWO_THIRDS_THR_RESET, ONE_THIRD_THR_RESET);
      run_random_ticks(90, 1'b0);
      set_thresholds(MV_MAX, MV_MAX, MV_MAX);
      run_random_ticks(90, 1'b0);
      set_sorted_thresholds();
      run_random_ticks(90, 1'b0);
      set_thresholds(MV_W'($urandom), MV_W'($urandom), MV_W'($urandom));
      run_random_ticks(90, 1'b0);
      set_thresholds(MV_MAX, 13'd4096, 13'd1);
      run_random_ticks(90, 1'b0);
   endtask

   task automatic test_alarm_latch();
      set_thresholds(FULL_THR_RESET, TWO_THIRDS_THR_RESET, ONE_THIRD_THR_RESET);
      if (armed_now) begin
         for (int i = 0; i < 3; i++)
            send_fields(13'd0, tick_with_residue(CHECK_PERIOD, CHECK_PERIOD - 4),
                        day_tracker + 1'b1);
      end
      for (int i = 0; i < 6; i++) send_random_tick(1'b0);
   endtask

   initial begin
      init_monitor_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_level_bands();
      test_empty_debounce();
      test_field_extremes();
      test_day_tracking();
      test_threshold_registers();
      test_random_armed();
      test_random_unrestricted();
      test_alarm_latch();
      settle();
      if (level_reports_q.size() != 0) flag_error("results still outstanding");
      if (mismatch_cnt == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
